### rtl/sha1_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_pkg
// Shared types, constants and round functions of the SHA-1 stream hasher.
// ----------------------------------------------------------------------------
package sha1_pkg;

    localparam int BLK_WORDS = 16;
    localparam int BLK_AW = $clog2(BLK_WORDS);
    localparam int HASH_WORDS = 5;
    localparam int ROUNDS = 80;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hEFCDAB89;
    localparam logic [31:0] IV2 = 32'h98BADCFE;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hC3D2E1F0;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_ROUND,
        ST_FINAL,
        ST_PAD
    } sha1_state_t;

    function automatic logic [31:0] iv_word(input logic [2:0] idx);
        logic [31:0] v;
        case (idx)
            3'd0:    v = IV0;
            3'd1:    v = IV1;
            3'd2:    v = IV2;
            3'd3:    v = IV3;
            default: v = IV4;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] round_k(input logic [6:0] t);
        logic [31:0] k;
        if (t < 7'd20)
            k = K0;
        else if (t < 7'd40)
            k = K1;
        else if (t < 7'd60)
            k = K2;
        else
            k = K3;
        return k;
    endfunction

    function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        if (t < 7'd20)
            f = (b & c) | (~b & d);
        else if (t < 7'd40)
            f = b ^ c ^ d;
        else if (t < 7'd60)
            f = (b & c) | (b & d) | (c & d);
        else
            f = b ^ c ^ d;
        return f;
    endfunction

endpackage

### rtl/sha1_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module sha1_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = sha1_pkg::BLK_WORDS
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/sha1_stream_hasher_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_stream_hasher_core
// SHA-1 over a message streamed as big-endian 32-bit words of 0 to 4 bytes.
// ----------------------------------------------------------------------------
// A word is taken while no block is being padded or compressed. Every
// 64th byte starts a compression (load, 80 rounds at one round a cycle,
// chain update) before the next word is taken.
// The last word triggers padding, written one word a cycle into the block RAM,
// and one or two further compressions; the digest then leaves through a
// five-word output buffer, h0 first, and the next message may start while
// it drains. Block words live in a 16-entry RAM that the rounds read in
// order; the schedule words beyond round 15 come from a 16-word window.
module sha1_stream_hasher_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [31:0] data_word, [34:32] byte_count
    input  logic        s_axis_tlast,   // last_word
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic        m_axis_tlast    // digest_last
);

    localparam int AW = sha1_pkg::BLK_AW;
    localparam int HW = sha1_pkg::HASH_WORDS;

    sha1_pkg::sha1_state_t state_reg, state_next;

    logic [5:0]  fill_reg, fill_next;
    logic [31:0] pend_reg, pend_next;
    logic [60:0] msg_reg, msg_next;
    logic [6:0]  rnd_reg, rnd_next;
    logic [AW-1:0] pad_idx_reg, pad_idx_next;
    logic        pad_first_reg, pad_first_next;
    logic        pad_started_reg, pad_started_next;
    logic        pad_pending_reg, pad_pending_next;
    logic        len_blk_reg, len_blk_next;
    logic        final_reg, final_next;
    logic        out_valid_reg, out_valid_next;
    logic [2:0]  out_idx_reg, out_idx_next;

    logic [31:0] chain_reg [HW];
    logic [31:0] chain_next [HW];
    logic [31:0] work_reg [HW];
    logic [31:0] work_next [HW];
    logic [31:0] win_reg [sha1_pkg::BLK_WORDS];
    logic [31:0] win_next [sha1_pkg::BLK_WORDS];
    logic [31:0] obuf_reg [HW];
    logic [31:0] obuf_next [HW];

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [31:0]   ram_rdata;

    logic        in_fire;
    logic        out_fire;
    logic [2:0]  cnt_raw;
    logic [2:0]  cnt_c;
    logic [31:0] dmask;
    logic [1:0]  off;
    logic [63:0] acc;
    logic [2:0]  total;
    logic        word_done;
    logic [6:0]  fill_sum;
    logic        blk_full;
    logic [AW-1:0] idx_now;
    logic        len_now;
    logic [63:0] bit_len;
    logic [31:0] pad_word;
    logic [31:0] w_t;
    logic [31:0] a_new;
    logic        out_busy_stall;

    sha1_ram #(
        .WIDTH(32),
        .DEPTH(sha1_pkg::BLK_WORDS)
    ) u_blk_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_axis_tready = (state_reg == sha1_pkg::ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = obuf_reg[out_idx_reg];
    assign m_axis_tlast  = (out_idx_reg == 3'(HW - 1));
    assign out_fire      = m_axis_tvalid && m_axis_tready;

    // byte packing of the incoming word
    assign cnt_raw   = s_axis_tdata[34:32];
    assign cnt_c     = (cnt_raw > 3'd4) ? 3'd4 : cnt_raw;
    assign dmask     = s_axis_tdata[31:0] & ~(32'hFFFF_FFFF >> {cnt_c, 3'b000});
    assign off       = fill_reg[1:0];
    assign acc       = {pend_reg, 32'h0} | ({dmask, 32'h0} >> {off, 3'b000});
    assign total     = {1'b0, off} + cnt_c;
    assign word_done = total[2];
    assign fill_sum  = {1'b0, fill_reg} + {4'b0000, cnt_c};
    assign blk_full  = fill_sum[6];

    // padding
    assign idx_now  = pad_first_reg ? fill_reg[5:2] : pad_idx_reg;
    assign len_now  = pad_first_reg ? (fill_reg[5:2] <= AW'(13)) : len_blk_reg;
    assign bit_len  = {msg_reg, 3'b000};
    assign pad_word = pend_reg | ({sha1_pkg::PAD_BYTE, 24'h0} >> {off, 3'b000});

    // round datapath
    assign w_t = (rnd_reg < 7'(sha1_pkg::BLK_WORDS)) ? ram_rdata
               : {win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0]} << 1
               | {31'h0, win_reg[13][31] ^ win_reg[8][31] ^ win_reg[2][31] ^ win_reg[0][31]};
    assign a_new = {work_reg[0][26:0], work_reg[0][31:27]}
                 + sha1_pkg::round_f(rnd_reg, work_reg[1], work_reg[2], work_reg[3])
                 + work_reg[4] + sha1_pkg::round_k(rnd_reg) + w_t;

    assign out_busy_stall = final_reg && out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sha1_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (blk_full)
                        state_next = sha1_pkg::ST_PREP;
                    else if (s_axis_tlast)
                        state_next = sha1_pkg::ST_PAD;
                end
            end
            sha1_pkg::ST_PREP:
                state_next = sha1_pkg::ST_ROUND;
            sha1_pkg::ST_ROUND:
            begin
                if (rnd_reg == 7'(sha1_pkg::ROUNDS - 1))
                    state_next = sha1_pkg::ST_FINAL;
            end
            sha1_pkg::ST_FINAL:
            begin
                if (final_reg)
                begin
                    if (!out_valid_reg)
                        state_next = sha1_pkg::ST_IDLE;
                end
                else if (pad_pending_reg)
                    state_next = sha1_pkg::ST_PAD;
                else
                    state_next = sha1_pkg::ST_IDLE;
            end
            sha1_pkg::ST_PAD:
            begin
                if (idx_now == AW'(sha1_pkg::BLK_WORDS - 1))
                    state_next = sha1_pkg::ST_PREP;
            end
            default:
                state_next = sha1_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        fill_next        = fill_reg;
        pend_next        = pend_reg;
        msg_next         = msg_reg;
        rnd_next         = rnd_reg;
        pad_idx_next     = pad_idx_reg;
        pad_first_next   = pad_first_reg;
        pad_started_next = pad_started_reg;
        pad_pending_next = pad_pending_reg;
        len_blk_next     = len_blk_reg;
        final_next       = final_reg;
        out_valid_next   = out_valid_reg;
        out_idx_next     = out_idx_reg;
        chain_next       = chain_reg;
        work_next        = work_reg;
        win_next         = win_reg;
        obuf_next        = obuf_reg;
        ram_we           = 1'b0;
        ram_waddr        = fill_reg[5:2];
        ram_wdata        = acc[63:32];
        ram_raddr        = '0;

        if (out_fire)
        begin
            if (m_axis_tlast)
            begin
                out_valid_next = 1'b0;
                out_idx_next   = '0;
            end
            else
            begin
                out_idx_next = out_idx_reg + 3'd1;
            end
        end

        unique case (state_reg)
            sha1_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    ram_we           = word_done;
                    pend_next        = word_done ? acc[31:0] : acc[63:32];
                    fill_next        = fill_sum[5:0];
                    msg_next         = msg_reg + {58'h0, cnt_c};
                    pad_pending_next = s_axis_tlast;
                    pad_started_next = 1'b0;
                    pad_first_next   = 1'b1;
                    final_next       = 1'b0;
                end
            end
            sha1_pkg::ST_PREP:
            begin
                work_next = chain_reg;
                rnd_next  = '0;
                ram_raddr = '0;
            end
            sha1_pkg::ST_ROUND:
            begin
                ram_raddr = rnd_reg[AW-1:0] + AW'(1);
                work_next[0] = a_new;
                work_next[1] = work_reg[0];
                work_next[2] = {work_reg[1][1:0], work_reg[1][31:2]};
                work_next[3] = work_reg[2];
                work_next[4] = work_reg[3];
                for (int i = 0; i < sha1_pkg::BLK_WORDS - 1; i++)
                begin
                    win_next[i] = win_reg[i + 1];
                end
                win_next[sha1_pkg::BLK_WORDS - 1] = w_t;
                rnd_next = rnd_reg + 7'd1;
            end
            sha1_pkg::ST_FINAL:
            begin
                rnd_next = '0;
                if (!out_busy_stall)
                begin
                    for (int i = 0; i < HW; i++)
                    begin
                        chain_next[i] = chain_reg[i] + work_reg[i];
                    end
                    if (final_reg)
                    begin
                        for (int i = 0; i < HW; i++)
                        begin
                            obuf_next[i]  = chain_reg[i] + work_reg[i];
                            chain_next[i] = sha1_pkg::iv_word(3'(i));
                        end
                        out_valid_next   = 1'b1;
                        out_idx_next     = '0;
                        fill_next        = '0;
                        pend_next        = '0;
                        msg_next         = '0;
                        pad_pending_next = 1'b0;
                        pad_started_next = 1'b0;
                        final_next       = 1'b0;
                    end
                    else if (pad_started_reg)
                    begin
                        pad_first_next = 1'b0;
                        pad_idx_next   = '0;
                        len_blk_next   = 1'b1;
                    end
                    else
                    begin
                        pad_first_next = 1'b1;
                    end
                end
            end
            sha1_pkg::ST_PAD:
            begin
                ram_we           = 1'b1;
                ram_waddr        = idx_now;
                pad_started_next = 1'b1;
                pad_first_next   = 1'b0;
                len_blk_next     = len_now;
                if (pad_first_reg)
                    ram_wdata = pad_word;
                else if (len_now && idx_now == AW'(14))
                    ram_wdata = bit_len[63:32];
                else if (len_now && idx_now == AW'(15))
                    ram_wdata = bit_len[31:0];
                else
                    ram_wdata = '0;
                if (idx_now == AW'(sha1_pkg::BLK_WORDS - 1))
                    final_next = len_now;
                else
                    pad_idx_next = idx_now + AW'(1);
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= sha1_pkg::ST_IDLE;
            fill_reg        <= '0;
            pend_reg        <= '0;
            msg_reg         <= '0;
            rnd_reg         <= '0;
            pad_idx_reg     <= '0;
            pad_first_reg   <= 1'b1;
            pad_started_reg <= 1'b0;
            pad_pending_reg <= 1'b0;
            len_blk_reg     <= 1'b0;
            final_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_idx_reg     <= '0;
            for (int i = 0; i < HW; i++)
            begin
                chain_reg[i] <= sha1_pkg::iv_word(3'(i));
            end
        end
        else
        begin
            state_reg       <= state_next;
            fill_reg        <= fill_next;
            pend_reg        <= pend_next;
            msg_reg         <= msg_next;
            rnd_reg         <= rnd_next;
            pad_idx_reg     <= pad_idx_next;
            pad_first_reg   <= pad_first_next;
            pad_started_reg <= pad_started_next;
            pad_pending_reg <= pad_pending_next;
            len_blk_reg     <= len_blk_next;
            final_reg       <= final_next;
            out_valid_reg   <= out_valid_next;
            out_idx_reg     <= out_idx_next;
            chain_reg       <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        win_reg  <= win_next;
        obuf_reg <= obuf_next;
    end

endmodule

### rtl/sha1_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_checker
// Port-level checks of the SHA-1 stream hasher, bound to the top level.
// ----------------------------------------------------------------------------
module sha1_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    logic [1:0] pend_cnt_reg, pend_cnt_next;
    logic [2:0] beat_cnt_reg, beat_cnt_next;
    logic       msg_in;
    logic       msg_out;

    assign msg_in  = s_axis_tvalid && s_axis_tready && s_axis_tlast;
    assign msg_out = m_axis_tvalid && m_axis_tready && m_axis_tlast;

    always_comb
    begin
        pend_cnt_next = pend_cnt_reg + {1'b0, msg_in} - {1'b0, msg_out};
        beat_cnt_next = beat_cnt_reg;
        if (m_axis_tvalid && m_axis_tready)
            beat_cnt_next = m_axis_tlast ? 3'd0 : beat_cnt_reg + 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_cnt_reg <= '0;
            beat_cnt_reg <= '0;
        end
        else
        begin
            pend_cnt_reg <= pend_cnt_next;
            beat_cnt_reg <= beat_cnt_next;
        end
    end

    // digest words only for a finished message
    a_out_needs_msg: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (pend_cnt_reg != 2'd0))
        else $error("digest word without a finished message");

    // last flag on the fifth word only
    a_last_on_fifth: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (beat_cnt_reg == 3'd4)))
        else $error("digest_last misplaced");

    // at most one digest waiting plus one message in flight
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        pend_cnt_reg != 2'd3)
        else $error("too many messages outstanding");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled digest word changed");

endmodule

bind sha1_stream_hasher_core sha1_checker u_sha1_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

### tb/sv/tb_sha1_stream_hasher_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sha1_stream_hasher_core
// Self-checking bench for the streaming SHA-1 hasher.
// ----------------------------------------------------------------------------
// Messages go in as stream requests of 0 to 4 bytes each. A SHA-1 predictor in
// the bench tracks the chaining state and queues the five digest words of every
// finished message. The output side checks each returned word and its tlast
// against that queue. A directed set covers the empty message, "abc", odd byte
// counts, zero-count words and a two-block pad. Random messages follow, with
// random gaps and stalls on both sides, one long output stall and two drains.
// ----------------------------------------------------------------------------
module tb_sha1_stream_hasher_core;

    localparam int QUIET_LIMIT = 5000;
    localparam int LONG_HOLD   = 700;
    localparam int LONG_AT     = 40;
    localparam int TAIL_CYCLES = 300;
    localparam int RAND_ITEMS  = 85;
    localparam int RAND_MSGS   = 10;

    typedef struct {
        logic [31:0] data;
        logic [2:0]  cnt;
        logic        last;
        bit          drain;
    } word_req_t;

    typedef struct packed {
        logic [31:0] hw;
        logic        is_h4;
    } digest_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;

    word_req_t   pending_reqs[$];
    digest_t     digest_exp[$];

    // predictor state
    logic [31:0] chain_h[5];
    logic [31:0] blk_w[16];
    int unsigned blk_fill;
    logic [60:0] msg_len;

    int          errors = 0;
    int          sent_cnt = 0;
    int          got_cnt = 0;
    int          total_reqs = 0;
    int          quiet_cycles = 0;

    sha1_stream_hasher_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 clk = ~clk;

    function automatic void restart_message();
        chain_h[0] = sha1_pkg::IV0;
        chain_h[1] = sha1_pkg::IV1;
        chain_h[2] = sha1_pkg::IV2;
        chain_h[3] = sha1_pkg::IV3;
        chain_h[4] = sha1_pkg::IV4;
        blk_fill = 0;
        msg_len = '0;
    endfunction

    function automatic void sha1_compress();
        logic [31:0] w[16];
        logic [31:0] a, b, c, d, e, f, k, x, tmp;
        w = blk_w;
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (int t = 0; t < 80; t++)
        begin
            if (t >= 16)
            begin
                x = w[(t - 3) & 15] ^ w[(t - 8) & 15] ^ w[(t - 14) & 15] ^ w[t & 15];
                w[t & 15] = {x[30:0], x[31]};
            end
            if (t < 20)
            begin
                f = (b & c) | (~b & d);
                k = sha1_pkg::K0;
            end
            else if (t < 40)
            begin
                f = b ^ c ^ d;
                k = sha1_pkg::K1;
            end
            else if (t < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = sha1_pkg::K2;
            end
            else
            begin
                f = b ^ c ^ d;
                k = sha1_pkg::K3;
            end
            tmp = {a[26:0], a[31:27]} + f + e + k + w[t & 15];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = tmp;
        end
        chain_h[0] += a;
        chain_h[1] += b;
        chain_h[2] += c;
        chain_h[3] += d;
        chain_h[4] += e;
    endfunction

    function automatic void push_octet(input logic [7:0] octet);
        blk_w[blk_fill >> 2][24 - 8 * (blk_fill & 3) +: 8] = octet;
        blk_fill++;
        if (blk_fill == 64)
        begin
            sha1_compress();
            blk_fill = 0;
        end
    endfunction

    function automatic void absorb_word(input word_req_t r);
        int          n;
        logic [63:0] bit_len;
        digest_t     dg;
        n = (r.cnt > 3'd4) ? 4 : int'(r.cnt);
        for (int i = 0; i < n; i++)
            push_octet(r.data[31 - 8 * i -: 8]);
        msg_len = msg_len + 61'(n);
        if (r.last)
        begin
            bit_len = {msg_len, 3'b000};
            push_octet(sha1_pkg::PAD_BYTE);
            while (blk_fill != 56)
                push_octet(8'h00);
            for (int i = 0; i < 8; i++)
                push_octet(bit_len[63 - 8 * i -: 8]);
            for (int i = 0; i < 5; i++)
            begin
                dg.hw = chain_h[i];
                dg.is_h4 = (i == 4);
                digest_exp.insert(digest_exp.size(), dg);
            end
            restart_message();
        end
    endfunction

    task automatic add_req(input logic [31:0] data, input logic [2:0] cnt,
                           input logic last, input bit drain);
        word_req_t r;
        r.data = data;
        r.cnt = cnt;
        r.last = last;
        r.drain = drain;
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    // random message: full words with some odd-count noise, then a last word
    task automatic add_message(input int body_words, input bit drain);
        logic [2:0] c;
        for (int i = 0; i < body_words; i++)
        begin
            c = 3'd4;
            if ($urandom_range(0, 99) < 15)
            begin
                c = 3'($urandom_range(0, 6));
                if (c >= 3'd4)
                    c = c + 3'd1;
            end
            add_req($urandom, c, 1'b0, drain && (i == 0));
        end
        add_req($urandom, 3'($urandom_range(0, 7)), 1'b1, drain && (body_words == 0));
    endtask

    // request driver
    word_req_t tx_req;
    int        tx_gap;
    bit        tx_burst = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tlast <= 1'b0;
            tx_gap = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                absorb_word(tx_req);
                sent_cnt++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_reqs.size() != 0 &&
                         !(pending_reqs[0].drain && digest_exp.size() != 0))
                begin
                    tx_req = pending_reqs.pop_front();
                    s_axis_tdata <= {5'd0, tx_req.cnt, tx_req.data};
                    s_axis_tlast <= tx_req.last;
                    s_axis_tvalid <= 1'b1;
                    if ($urandom_range(0, 15) == 0)
                        tx_burst = !tx_burst;
                    tx_gap = tx_burst ? 0 : $urandom_range(0, 16);
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // digest monitor
    digest_t rx_exp;
    int      rx_hold;
    bit      rx_burst = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_hold = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (digest_exp.size() == 0)
                begin
                    $display("%0t: unexpected digest word %h last %b", $time,
                             m_axis_tdata, m_axis_tlast);
                    errors++;
                end
                else
                begin
                    rx_exp = digest_exp.pop_front();
                    if (m_axis_tdata !== rx_exp.hw)
                    begin
                        $display("%0t: digest word mismatch: expected %h, got %h", $time,
                                 rx_exp.hw, m_axis_tdata);
                        errors++;
                    end
                    if (m_axis_tlast !== rx_exp.is_h4)
                    begin
                        $display("%0t: tlast mismatch: expected %b, got %b", $time,
                                 rx_exp.is_h4, m_axis_tlast);
                        errors++;
                    end
                end
                got_cnt++;
                if ($urandom_range(0, 15) == 0)
                    rx_burst = !rx_burst;
                if (got_cnt == LONG_AT)
                    rx_hold = LONG_HOLD;
                else
                    rx_hold = rx_burst ? 0 : $urandom_range(0, 16);
            end
            if (rx_hold > 0)
            begin
                rx_hold--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: watchdog, no handshake for %0d cycles", $time, QUIET_LIMIT);
            $display("** sha1_stream_hasher_core: FAILED **");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int rand_items;
        int rand_msgs;
        int body;
        int pick;
        bit mid_drain_done;

        blk_w = '{default: 32'h0};
        restart_message();

        // empty message, ignored bytes all ones
        add_req(32'hFFFF_FFFF, 3'd0, 1'b1, 1'b0);
        // "abc"
        add_req(32'h6162_6300, 3'd3, 1'b1, 1'b0);
        // zero count, count above four, partial words mid-stream, count 5 on last
        add_req(32'hDEAD_BEEF, 3'd0, 1'b0, 1'b0);
        add_req(32'hFFFF_FFFF, 3'd7, 1'b0, 1'b0);
        add_req(32'h9ABC_DEF0, 3'd1, 1'b0, 1'b0);
        add_req(32'h1234_5678, 3'd2, 1'b0, 1'b0);
        add_req(32'h0000_0000, 3'd5, 1'b1, 1'b0);
        // 56 bytes: pad spills into a second block
        for (int i = 0; i < 13; i++)
            add_req($urandom, 3'd4, 1'b0, 1'b0);
        add_req($urandom, 3'd4, 1'b1, 1'b0);

        rand_items = 0;
        rand_msgs = 0;
        mid_drain_done = 1'b0;
        while (rand_items < RAND_ITEMS || rand_msgs < RAND_MSGS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
                body = $urandom_range(0, 4);
            else if (pick < 90)
                body = $urandom_range(13, 17);
            else
                body = $urandom_range(18, 33);
            if (rand_msgs == 0)
                add_message(body, 1'b1);
            else if (!mid_drain_done && rand_items >= 70)
            begin
                add_message(body, 1'b1);
                mid_drain_done = 1'b1;
            end
            else
                add_message(body, 1'b0);
            rand_items += body + 1;
            rand_msgs++;
        end
        total_reqs = pending_reqs.size();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (sent_cnt < total_reqs || digest_exp.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("** sha1_stream_hasher_core: PASSED **");
        else
            $display("** sha1_stream_hasher_core: FAILED **");
        $finish;
    end

endmodule
